// File: rtl/ple_pkg.sv
// Package for the positional list engine: opcodes, result status codes,
// controller states and the command broadcast to the row of storage cells.
// No dependencies.
`default_nettype none

package ple_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int DATA_W   = 32;
   localparam int POS_W    = 6;
   localparam int COUNT_W  = 7;
   localparam int OPCODE_W = 3;
   localparam int STATUS_W = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_APPEND  = 3'd0,
      OP_PREPEND = 3'd1,
      OP_INSERT  = 3'd2,
      OP_REMOVE  = 3'd3,
      OP_DUMP    = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_RANGE = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_DUMP = 1'b1
   } fsm_state_type;

   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_ROTATE = 2'd3
   } cmd_kind_type;

   // Command seen by every cell in the same cycle.
   typedef struct packed {
      cmd_kind_type              kind;
      logic [COUNT_W-1:0]        pos;
      logic [COUNT_W-1:0]        len;
      logic signed [DATA_W-1:0]  value;
   } cell_cmd_type;

endpackage

`default_nettype wire

// File: rtl/ple_cell.sv
// One storage cell of the positional list engine: holds one element and
// takes a new value from itself, its neighbours, the head cell or the input.
// Depends on ple_pkg.
`default_nettype none

module ple_cell
   import ple_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  wire logic                      clock,
   input  wire cell_cmd_type              cmd,
   input  wire logic signed [DATA_W-1:0]  left_value,
   input  wire logic signed [DATA_W-1:0]  right_value,
   input  wire logic signed [DATA_W-1:0]  head_value,
   output logic signed [DATA_W-1:0]       cell_value
);

   localparam logic [COUNT_W-1:0] IDX      = COUNT_W'(INDEX);
   localparam logic [COUNT_W-1:0] IDX_NEXT = COUNT_W'(INDEX + 1);

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (cmd.kind)
         CMD_INSERT: begin
            // Cells behind the gap move one place towards the tail.
            if (IDX == cmd.pos) begin
               value_in = cmd.value;
            end else if (IDX > cmd.pos) begin
               value_in = left_value;
            end
         end
         CMD_REMOVE: begin
            if (IDX >= cmd.pos) begin
               value_in = right_value;
            end
         end
         CMD_ROTATE: begin
            // The occupied cells turn one place towards the head.
            if (IDX_NEXT == cmd.len) begin
               value_in = head_value;
            end else if (IDX_NEXT < cmd.len) begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cell_value = value_ff;

endmodule

`default_nettype wire

// File: rtl/positional_list_engine_top.sv
// Top level of the positional list engine: command decode, length counter,
// result register and the row of ple_cell storage cells.
// Depends on ple_pkg and ple_cell.
`default_nettype none

// Usage
// A bounded ordered list of up to DEPTH signed 32-bit elements, head first.
// A command transaction is accepted at a rising edge where start is high and
// busy is low; it carries an opcode, a position and a value. Append, prepend,
// insert and remove act on all cells at once: every cell loads from itself,
// a neighbour or the input in the same cycle, so these commands may follow
// one another on every clock. Their single result appears on the rsp_ ports
// in the cycle after acceptance, with rsp_last set.
// Dump walks the list by turning the occupied cells one place towards the
// head on each cycle and reading the head cell; busy is high while it runs.
// Its results are read from the head cell in the dump state, pass through
// the result register and appear one per cycle, the last one flagged.
// After count turns the list is back in its original order. A dump of an
// empty list gives one result with status empty. Each result is held on the
// rsp_ ports for exactly one cycle while rsp_valid is high; the receiver
// cannot stall it, so no result is ever held back. Synchronous reset empties
// the list and clears the controller; the cell contents are not cleared, as
// no cell is read before it has been written.
module positional_list_engine_top
   import ple_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [OPCODE_W-1:0]       req_opcode,
   input  wire logic [POS_W-1:0]          req_position,
   input  wire logic signed [DATA_W-1:0]  req_item_value,
   output logic                           rsp_valid,
   output logic signed [DATA_W-1:0]       rsp_read_value,
   output logic [STATUS_W-1:0]            rsp_status,
   output logic [COUNT_W-1:0]             rsp_count,
   output logic                           rsp_last
);

   localparam int LEN_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(DEPTH);

   // Controller state.
   fsm_state_type             state_ff, state_in;
   logic [LEN_W-1:0]          len_ff, len_in;
   logic [IDX_W-1:0]          dump_idx_ff, dump_idx_in;

   // Result register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0]          rsp_count_ff, rsp_count_in;
   logic                      rsp_last_ff, rsp_last_in;

   cell_cmd_type              cmd;
   logic signed [DATA_W-1:0]  cell_value [DEPTH];

   logic                      accept;
   logic [COUNT_W-1:0]        pos_ext;
   logic [COUNT_W-1:0]        len_ext;
   logic                      is_full;
   logic                      is_empty;
   logic                      dump_final;

   assign accept     = start && (state_ff == FSM_IDLE);
   assign pos_ext    = COUNT_W'(req_position);
   assign len_ext    = COUNT_W'(len_ff);
   assign is_full    = (len_ff == LEN_FULL);
   assign is_empty   = (len_ff == '0);
   assign dump_final = ((LEN_W'(dump_idx_ff) + LEN_W'(1)) == len_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         len_ff       <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Command decode, length update and dump sequencing.
   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      dump_idx_in   = dump_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = '0;
      rsp_status_in = STAT_OK;
      rsp_count_in  = len_ff;
      rsp_last_in   = 1'b1;
      cmd.kind      = CMD_HOLD;
      cmd.pos       = '0;
      cmd.len       = len_ext;
      cmd.value     = req_item_value;

      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               case (req_opcode)
                  OP_APPEND, OP_PREPEND, OP_INSERT: begin
                     if (is_full) begin
                        rsp_status_in = STAT_FULL;
                     end else if ((req_opcode == OP_INSERT) && (pos_ext > len_ext)) begin
                        rsp_status_in = STAT_RANGE;
                     end else begin
                        cmd.kind = CMD_INSERT;
                        if (req_opcode == OP_APPEND) begin
                           cmd.pos = len_ext;
                        end else if (req_opcode == OP_PREPEND) begin
                           cmd.pos = '0;
                        end else begin
                           cmd.pos = pos_ext;
                        end
                        len_in       = len_ff + LEN_W'(1);
                        rsp_count_in = len_ff + LEN_W'(1);
                     end
                  end
                  OP_REMOVE: begin
                     if (is_empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else if (pos_ext >= len_ext) begin
                        rsp_status_in = STAT_RANGE;
                     end else begin
                        cmd.kind     = CMD_REMOVE;
                        cmd.pos      = pos_ext;
                        len_in       = len_ff - LEN_W'(1);
                        rsp_count_in = len_ff - LEN_W'(1);
                     end
                  end
                  OP_DUMP: begin
                     if (is_empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        // Elements follow from the dump state.
                        rsp_valid_in = 1'b0;
                        dump_idx_in  = '0;
                        state_in     = FSM_DUMP;
                     end
                  end
                  default: begin
                     rsp_status_in = STAT_OK;
                  end
               endcase
            end
         end
         FSM_DUMP: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = cell_value[0];
            rsp_last_in  = dump_final;
            cmd.kind     = CMD_ROTATE;
            dump_idx_in  = dump_idx_ff + IDX_W'(1);
            if (dump_final) begin
               dump_idx_in = '0;
               state_in    = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // The row of cells; each sees its neighbours and the head.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      ple_cell #(
         .INDEX(i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_value (cell_value[(i == 0) ? 0 : i - 1]),
         .right_value(cell_value[(i == DEPTH - 1) ? DEPTH - 1 : i + 1]),
         .head_value (cell_value[0]),
         .cell_value (cell_value[i])
      );
   end

   assign busy           = (state_ff == FSM_DUMP);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = COUNT_W'(rsp_count_ff);
   assign rsp_last       = rsp_last_ff;

   // A dump is only ever under way on a non-empty list.
   a_dump_nonempty: assert property (@(posedge clock) disable iff (reset)
      busy |-> (len_ff != '0))
      else $error("dump running on an empty list");

   // The list never grows beyond its capacity.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_FULL)
      else $error("list length exceeds capacity");

   // A full status is only reported when the list is at capacity.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STAT_FULL)) |-> (rsp_count == COUNT_W'(DEPTH)))
      else $error("full status with spare capacity");

   // Dump results come back to back until the flagged final one.
   a_dump_stream: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid)
      else $error("gap in dump results");

endmodule

`default_nettype wire
